// ===== rtl/core/rbce_pkg.sv =====
package rbce_pkg;

  // Field widths
  localparam int DATA_W   = 8;
  localparam int WORD_W   = 32;
  localparam int ADDR_W   = 19;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 6;

  // Bank geometry
  localparam int MAX_BANKS  = 32;
  localparam int BANK_BYTES = 16384;
  localparam int BANK_W     = $clog2(MAX_BANKS);
  localparam int OFF_W      = $clog2(BANK_BYTES) + 1;
  localparam int BANK_NUM_W = 7;

  // Header sizes
  localparam int HDR_BYTES      = 8;
  localparam int FILE_HDR_BYTES = 12;

  // Tag characters
  localparam logic [DATA_W-1:0] CH_C = 8'h63;
  localparam logic [DATA_W-1:0] CH_B = 8'h62;
  localparam logic [DATA_W-1:0] CH_0 = 8'h30;
  localparam logic [DATA_W-1:0] CH_9 = 8'h39;

  typedef enum logic [2:0] {
    PH_FILEHDR = 3'd0,
    PH_CHDR    = 3'd1,
    PH_DATA    = 3'd2,
    PH_PAD     = 3'd3,
    PH_IGNORE  = 3'd4
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_PARSING   = 3'd0,
    ST_LOADED    = 3'd1,
    ST_TOO_SMALL = 3'd2,
    ST_BAD_SIG   = 3'd3,
    ST_NO_BANKS  = 3'd4
  } status_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              last_byte;
  } rbce_item_t;

  typedef struct packed {
    logic               write_valid;
    logic [ADDR_W-1:0]  rom_address;
    logic [DATA_W-1:0]  rom_byte;
    status_t            status;
    logic [COUNT_W-1:0] bank_count;
    logic [WORD_W-1:0]  total_bytes;
  } rbce_result_t;

  // File header check: "RIFF" at 0..3, "AMS!" at 8..11, size field ignored
  function automatic logic sig_match(logic [3:0] idx, logic [DATA_W-1:0] d);
    logic ok;
    case (idx)
      4'd0:    ok = (d == 8'h52);
      4'd1:    ok = (d == 8'h49);
      4'd2:    ok = (d == 8'h46);
      4'd3:    ok = (d == 8'h46);
      4'd8:    ok = (d == 8'h41);
      4'd9:    ok = (d == 8'h4D);
      4'd10:   ok = (d == 8'h53);
      4'd11:   ok = (d == 8'h21);
      default: ok = 1'b1;
    endcase
    return ok;
  endfunction

endpackage

// ===== rtl/core/rbce_if.sv =====
// Input byte channel
interface rbce_in_if import rbce_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

// Result channel
interface rbce_out_if import rbce_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                write_valid;
  logic [ADDR_W-1:0]   rom_address;
  logic [DATA_W-1:0]   rom_byte;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  bank_count;
  logic [WORD_W-1:0]   total_bytes;

  modport source (output valid, write_valid, rom_address, rom_byte, status, bank_count,
                  total_bytes, input ready);
  modport sink   (input valid, write_valid, rom_address, rom_byte, status, bank_count,
                  total_bytes, output ready);
endinterface

// File length register write channel
interface rbce_cfg_if import rbce_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] file_length;

  modport source (output valid, file_length, input ready);
  modport sink   (input valid, file_length, output ready);
endinterface

// ===== rtl/core/rbce_parse.sv =====
module rbce_parse import rbce_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  rbce_item_t        item,
  input  logic [WORD_W-1:0] file_length,
  output rbce_result_t      res
);

  logic [WORD_W-1:0]  byte_pos_r, byte_pos_nxt;
  phase_t             phase_r, phase_nxt;
  logic               sig_ok_r, sig_ok_nxt;
  logic [WORD_W-1:0]  tag_r, tag_nxt;
  logic [WORD_W-1:0]  len_r, len_nxt;
  logic [WORD_W-1:0]  remain_r, remain_nxt;
  logic               pad_r, pad_nxt;
  logic [BANK_W-1:0]  bank_r, bank_nxt;
  logic               copy_en_r, copy_en_nxt;
  logic [OFF_W-1:0]   offset_r, offset_nxt;
  logic [COUNT_W-1:0] banks_r, banks_nxt;
  logic [WORD_W-1:0]  loaded_r, loaded_nxt;

  logic [WORD_W-1:0]     pos_next;
  logic                  sig_ok_new;
  logic                  hdr_room;
  phase_t                hdr_phase;
  logic [2:0]            hdr_idx;
  logic [WORD_W-1:0]     tag_new, len_new;
  logic [DATA_W-1:0]     t0, t1, t2, t3;
  logic                  dig2, dig3, is_bank;
  logic [BANK_NUM_W-1:0] d2, d3, bank_val;
  logic                  fits, take;
  logic [WORD_W-1:0]     copy_len;
  logic [WORD_W-1:0]     remain_dec;
  logic                  finish, take_now;
  logic                  write_en;
  logic [COUNT_W-1:0]    banks_upd;
  logic [WORD_W-1:0]     loaded_upd;

  // Position saturates at all ones
  assign pos_next = (&byte_pos_r) ? byte_pos_r : byte_pos_r + WORD_W'(1);

  // Signature check over the file header bytes
  assign sig_ok_new = (phase_r == PH_FILEHDR && byte_pos_r < WORD_W'(FILE_HDR_BYTES) &&
                       !sig_match(byte_pos_r[3:0], item.data_byte)) ? 1'b0 : sig_ok_r;

  // Room for another chunk header
  assign hdr_room  = ({1'b0, pos_next} + (WORD_W+1)'(HDR_BYTES)) <= {1'b0, file_length};
  assign hdr_phase = hdr_room ? PH_CHDR : PH_IGNORE;

  // Header byte insertion: tag bytes 0..3, length bytes 4..7, little endian
  assign hdr_idx = 3'(4'(HDR_BYTES) - remain_r[3:0]);
  assign tag_new = hdr_idx[2] ? tag_r
                 : tag_r | (WORD_W'(item.data_byte) << {hdr_idx[1:0], 3'b000});
  assign len_new = hdr_idx[2] ? len_r | (WORD_W'(item.data_byte) << {hdr_idx[1:0], 3'b000})
                 : len_r;

  // Bank tag decode
  assign t0 = tag_new[7:0];
  assign t1 = tag_new[15:8];
  assign t2 = tag_new[23:16];
  assign t3 = tag_new[31:24];
  assign dig2 = (t2 >= CH_0) && (t2 <= CH_9);
  assign dig3 = (t3 >= CH_0) && (t3 <= CH_9);
  assign is_bank = (t0 == CH_C) && (t1 == CH_B) && dig2;
  assign d2 = BANK_NUM_W'(t2 - CH_0);
  assign d3 = BANK_NUM_W'(t3 - CH_0);
  assign bank_val = is_bank ? (dig3 ? BANK_NUM_W'(d2 * BANK_NUM_W'(10)) + d3 : d2)
                            : '0;

  // Chunk must fit inside the file
  assign fits = ({1'b0, pos_next} + {1'b0, len_new}) <= {1'b0, file_length};
  assign take = is_bank && (bank_val < BANK_NUM_W'(MAX_BANKS)) && fits;
  assign copy_len = (len_new > WORD_W'(BANK_BYTES)) ? WORD_W'(BANK_BYTES) : len_new;

  assign remain_dec = remain_r - WORD_W'(1);
  assign finish     = (phase_r == PH_CHDR) && (remain_dec == '0);
  assign take_now   = finish && take;

  // Running bank count and byte total
  assign banks_upd  = (take_now && bank_val >= BANK_NUM_W'(banks_r))
                    ? COUNT_W'(bank_val + BANK_NUM_W'(1)) : banks_r;
  assign loaded_upd = take_now ? loaded_r + copy_len : loaded_r;

  assign write_en = (phase_r == PH_DATA) && copy_en_r && (offset_r < OFF_W'(BANK_BYTES));

  // Next state
  always_comb begin
    byte_pos_nxt = pos_next;
    phase_nxt    = phase_r;
    sig_ok_nxt   = sig_ok_new;
    tag_nxt      = tag_r;
    len_nxt      = len_r;
    remain_nxt   = remain_r;
    pad_nxt      = pad_r;
    bank_nxt     = bank_r;
    copy_en_nxt  = copy_en_r;
    offset_nxt   = offset_r;
    banks_nxt    = banks_upd;
    loaded_nxt   = loaded_upd;

    case (phase_r)
      PH_FILEHDR: begin
        if (byte_pos_r >= WORD_W'(FILE_HDR_BYTES - 1)) begin
          if (file_length < WORD_W'(FILE_HDR_BYTES) || !sig_ok_new) begin
            phase_nxt = PH_IGNORE;
          end else begin
            phase_nxt  = hdr_phase;
            remain_nxt = WORD_W'(HDR_BYTES);
            tag_nxt    = '0;
            len_nxt    = '0;
          end
        end
      end
      PH_CHDR: begin
        tag_nxt    = tag_new;
        len_nxt    = len_new;
        remain_nxt = remain_dec;
        if (finish) begin
          copy_en_nxt = take;
          if (take) begin
            bank_nxt   = BANK_W'(bank_val);
            offset_nxt = '0;
          end
          pad_nxt    = len_new[0];
          remain_nxt = len_new;
          if (len_new == '0) begin
            // empty chunk: no pad, straight to the next header
            phase_nxt  = hdr_phase;
            remain_nxt = WORD_W'(HDR_BYTES);
            tag_nxt    = '0;
            len_nxt    = '0;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        if (write_en) begin
          offset_nxt = offset_r + OFF_W'(1);
        end
        remain_nxt = remain_dec;
        if (remain_dec == '0) begin
          if (pad_r) begin
            phase_nxt = PH_PAD;
          end else begin
            phase_nxt  = hdr_phase;
            remain_nxt = WORD_W'(HDR_BYTES);
            tag_nxt    = '0;
            len_nxt    = '0;
          end
        end
      end
      PH_PAD: begin
        phase_nxt  = hdr_phase;
        remain_nxt = WORD_W'(HDR_BYTES);
        tag_nxt    = '0;
        len_nxt    = '0;
      end
      default: begin
      end
    endcase

    // End of file: back to the start for the next file
    if (item.last_byte) begin
      byte_pos_nxt = '0;
      phase_nxt    = PH_FILEHDR;
      sig_ok_nxt   = 1'b1;
      tag_nxt      = '0;
      len_nxt      = '0;
      remain_nxt   = '0;
      pad_nxt      = 1'b0;
      bank_nxt     = '0;
      copy_en_nxt  = 1'b0;
      offset_nxt   = '0;
      banks_nxt    = '0;
      loaded_nxt   = '0;
    end
  end

  // Result for the current byte
  always_comb begin
    res.write_valid = write_en;
    res.rom_address = write_en ? ADDR_W'(ADDR_W'(bank_r) * ADDR_W'(BANK_BYTES))
                                 + ADDR_W'(offset_r) : '0;
    res.rom_byte    = write_en ? item.data_byte : '0;
    res.bank_count  = banks_upd;
    res.total_bytes = loaded_upd;
    res.status      = ST_PARSING;
    if (item.last_byte) begin
      if (byte_pos_r < WORD_W'(FILE_HDR_BYTES - 1) || file_length < WORD_W'(FILE_HDR_BYTES)) begin
        res.status = ST_TOO_SMALL;
      end else if (!sig_ok_new) begin
        res.status = ST_BAD_SIG;
      end else if (banks_upd == '0) begin
        res.status = ST_NO_BANKS;
      end else begin
        res.status = ST_LOADED;
      end
    end
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r <= '0;
      phase_r    <= PH_FILEHDR;
      sig_ok_r   <= 1'b1;
      tag_r      <= '0;
      len_r      <= '0;
      remain_r   <= '0;
      pad_r      <= 1'b0;
      bank_r     <= '0;
      copy_en_r  <= 1'b0;
      offset_r   <= '0;
      banks_r    <= '0;
      loaded_r   <= '0;
    end else if (step) begin
      byte_pos_r <= byte_pos_nxt;
      phase_r    <= phase_nxt;
      sig_ok_r   <= sig_ok_nxt;
      tag_r      <= tag_nxt;
      len_r      <= len_nxt;
      remain_r   <= remain_nxt;
      pad_r      <= pad_nxt;
      bank_r     <= bank_nxt;
      copy_en_r  <= copy_en_nxt;
      offset_r   <= offset_nxt;
      banks_r    <= banks_nxt;
      loaded_r   <= loaded_nxt;
    end
  end

  // Checks
  a_write_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    res.write_valid |-> (phase_r == PH_DATA) && copy_en_r)
    else $error("rom write outside an accepted bank chunk");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.last_byte |=> (phase_r == PH_FILEHDR) && (byte_pos_r == '0) && (banks_r == '0))
    else $error("parse state not cleared after last byte");

  a_banks_max: assert property (@(posedge clk) disable iff (!rst_n)
    banks_r <= COUNT_W'(MAX_BANKS))
    else $error("bank count above bank limit");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res.status != ST_PARSING) |-> item.last_byte)
    else $error("final status reported before last byte");

endmodule

// ===== rtl/core/riff_bank_chunk_extractor.sv =====
// Channel  Dir  Handshake     Payload
// in_ch    in   valid/ready   data_byte[7:0], last_byte
// out_ch   out  valid/ready   write_valid, rom_address[18:0], rom_byte[7:0], status[2:0],
//                             bank_count[5:0], total_bytes[31:0]
// cfg_ch   in   valid/ready   file_length[31:0] (ready always high)
//
// One byte per cycle sustained while out_ch is ready; each byte passes from in_ch to out_ch
// through two registers (input register, then parse logic into the result register).
// A single parse stage of combinational logic lies between the two registers.
// Synchronous active-low reset returns the parse state to the file header phase and clears file_length to zero.
// A stalled result holds in the output register while one more byte waits in the
// input register; in_ch drops ready only when both are full.
module riff_bank_chunk_extractor import rbce_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  rbce_in_if.sink    in_ch,
  rbce_out_if.source out_ch,
  rbce_cfg_if.sink   cfg_ch
);

  logic              s1_valid_r, s1_valid_nxt;
  rbce_item_t        s1_item_r;
  logic              out_valid_r, out_valid_nxt;
  rbce_result_t      out_res_r;
  logic [WORD_W-1:0] file_length_r;

  logic         in_fire;
  logic         out_free;
  logic         step;
  rbce_result_t res;

  // Pipeline flow control
  assign out_free     = !out_valid_r || out_ch.ready;
  assign step         = s1_valid_r && out_free;
  assign in_ch.ready  = !s1_valid_r || out_free;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (step ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = step ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  rbce_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .item        (s1_item_r),
    .file_length (file_length_r),
    .res         (res)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      file_length_r <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        file_length_r <= cfg_ch.file_length;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.data_byte <= in_ch.data_byte;
      s1_item_r.last_byte <= in_ch.last_byte;
    end
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.write_valid = out_res_r.write_valid;
  assign out_ch.rom_address = out_res_r.rom_address;
  assign out_ch.rom_byte    = out_res_r.rom_byte;
  assign out_ch.status      = out_res_r.status;
  assign out_ch.bank_count  = out_res_r.bank_count;
  assign out_ch.total_bytes = out_res_r.total_bytes;

  // Checks
  a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("parsed byte lost before result register");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |=> s1_valid_r && $stable(s1_item_r))
    else $error("input register changed while parse stage stalled");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |-> !in_fire)
    else $error("byte accepted into a full input register");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

import rbce_pkg::*;

// Tracks the chunk walk byte by byte and holds the results still owed by the block
class chunk_walk_checker;
  logic [WORD_W-1:0]  file_len;
  logic [WORD_W-1:0]  byte_pos;
  phase_t             phase;
  bit                 sig_ok;
  logic [WORD_W-1:0]  tag_word;
  logic [WORD_W-1:0]  len_word;
  logic [WORD_W-1:0]  left;
  bit                 pad_due;
  logic [BANK_W-1:0]  bank;
  bit                 copying;
  logic [OFF_W-1:0]   offset;
  logic [COUNT_W-1:0] banks;
  logic [WORD_W-1:0]  loaded;
  logic [DATA_W-1:0]  riff_form [FILE_HDR_BYTES];
  rbce_result_t       expected_q[$];
  int                 errors;
  int                 rom_writes;
  int                 files;
  int                 status_seen [5];

  function new();
    riff_form = '{8'h52, 8'h49, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00,
                  8'h41, 8'h4D, 8'h53, 8'h21};
    file_len = '0;
    errors = 0;
    rom_writes = 0;
    files = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    restart();
  endfunction

  function void restart();
    byte_pos = '0;
    phase = PH_FILEHDR;
    sig_ok = 1'b1;
    tag_word = '0;
    len_word = '0;
    left = '0;
    pad_due = 1'b0;
    bank = '0;
    copying = 1'b0;
    offset = '0;
    banks = '0;
    loaded = '0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Next chunk header only if all 8 header bytes still lie inside the file
  function void open_header(logic [WORD_W-1:0] p);
    if ({1'b0, p} + 33'(HDR_BYTES) <= {1'b0, file_len}) begin
      phase = PH_CHDR;
      left = WORD_W'(HDR_BYTES);
      tag_word = '0;
      len_word = '0;
    end else begin
      phase = PH_IGNORE;
    end
  endfunction

  function void close_data(logic [WORD_W-1:0] p);
    if (pad_due) phase = PH_PAD;
    else open_header(p);
  endfunction

  // Decode tag: "cb" plus one or two digits names a bank
  function void close_header(logic [WORD_W-1:0] p);
    logic [DATA_W-1:0] c0, c1, c2, c3;
    logic [6:0]        num;
    bit                is_bank, two_digits, fits;
    c0 = tag_word[7:0];
    c1 = tag_word[15:8];
    c2 = tag_word[23:16];
    c3 = tag_word[31:24];
    is_bank = (c0 == CH_C) && (c1 == CH_B) && (c2 >= CH_0) && (c2 <= CH_9);
    two_digits = (c3 >= CH_0) && (c3 <= CH_9);
    num = '0;
    if (is_bank) num = two_digits ? 7'((c2 - CH_0) * 10 + (c3 - CH_0)) : 7'(c2 - CH_0);
    fits = ({1'b0, p} + {1'b0, len_word}) <= {1'b0, file_len};
    copying = is_bank && (num < MAX_BANKS) && fits;
    if (copying) begin
      bank = num[BANK_W-1:0];
      offset = '0;
      if (num >= banks) banks = COUNT_W'(num + 1);
      loaded = loaded + ((len_word > BANK_BYTES) ? WORD_W'(BANK_BYTES) : len_word);
    end
    pad_due = len_word[0];
    left = len_word;
    if (len_word == 0) close_data(p);
    else phase = PH_DATA;
  endfunction

  // One accepted request in, one expected result queued
  function void note_request(logic [DATA_W-1:0] d, logic last);
    logic [WORD_W-1:0] pos, nxt;
    logic [2:0]        idx;
    rbce_result_t      r;
    pos = byte_pos;
    nxt = (pos == '1) ? pos : pos + 1;
    r = '0;
    r.status = ST_PARSING;
    case (phase)
      PH_FILEHDR: begin
        if ((pos < 4 || (pos >= 8 && pos < FILE_HDR_BYTES)) && d != riff_form[pos[3:0]])
          sig_ok = 1'b0;
        if (pos >= FILE_HDR_BYTES - 1) begin
          if (file_len < FILE_HDR_BYTES || !sig_ok) phase = PH_IGNORE;
          else open_header(nxt);
        end
      end
      PH_CHDR: begin
        idx = 3'(HDR_BYTES - left);
        if (idx < 4) tag_word = tag_word | (WORD_W'(d) << (8 * idx));
        else len_word = len_word | (WORD_W'(d) << (8 * (idx - 4)));
        left = left - 1;
        if (left == 0) close_header(nxt);
      end
      PH_DATA: begin
        if (copying && offset < BANK_BYTES) begin
          r.write_valid = 1'b1;
          r.rom_address = ADDR_W'(bank * BANK_BYTES + offset);
          r.rom_byte = d;
          offset = offset + OFF_W'(1);
          rom_writes++;
        end
        left = left - 1;
        if (left == 0) close_data(nxt);
      end
      PH_PAD: open_header(nxt);
      default: ;
    endcase
    byte_pos = nxt;
    if (last) begin
      if (pos < FILE_HDR_BYTES - 1 || file_len < FILE_HDR_BYTES) r.status = ST_TOO_SMALL;
      else if (!sig_ok) r.status = ST_BAD_SIG;
      else if (banks == 0) r.status = ST_NO_BANKS;
      else r.status = ST_LOADED;
      files++;
      status_seen[r.status]++;
    end
    r.bank_count = banks;
    r.total_bytes = loaded;
    expected_q.push_back(r);
    if (last) restart();
  endfunction

  function void mismatch(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    errors++;
    $display("%0t: %s expected %h, got %h", $time, field, want, got);
  endfunction

  // Oldest expectation against the result just accepted
  function void check_result(rbce_result_t got);
    rbce_result_t want;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: result with none expected, expected nothing, got wv %b addr %h",
               $time, got.write_valid, got.rom_address);
      return;
    end
    want = expected_q.pop_front();
    if (got.write_valid !== want.write_valid)
      mismatch("write_valid", WORD_W'(want.write_valid), WORD_W'(got.write_valid));
    if (got.rom_address !== want.rom_address)
      mismatch("rom_address", WORD_W'(want.rom_address), WORD_W'(got.rom_address));
    if (got.rom_byte !== want.rom_byte)
      mismatch("rom_byte", WORD_W'(want.rom_byte), WORD_W'(got.rom_byte));
    if (got.status !== want.status)
      mismatch("status", WORD_W'(want.status), WORD_W'(got.status));
    if (got.bank_count !== want.bank_count)
      mismatch("bank_count", WORD_W'(want.bank_count), WORD_W'(got.bank_count));
    if (got.total_bytes !== want.total_bytes)
      mismatch("total_bytes", want.total_bytes, got.total_bytes);
  endfunction
endclass

module tb;
  localparam int RANDOM_ITEMS   = 1350;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam logic [WORD_W-1:0] RIFF_ID = "RIFF";
  localparam logic [WORD_W-1:0] FORM_ID = "AMS!";

  logic clk;
  logic rst_n;

  rbce_in_if  in_bus ();
  rbce_out_if out_bus ();
  rbce_cfg_if cfg_bus ();

  riff_bank_chunk_extractor u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  chunk_walk_checker sb = new();

  logic [DATA_W-1:0] file_q[$];
  bit                no_idle;
  int                stuck_cycles;
  int                length_writes;
  int                items_sent;
  rbce_result_t      seen_result;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Monitor the input and result channels, feed the checker, watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) sb.note_request(in_bus.data_byte, in_bus.last_byte);
      if (out_bus.valid && out_bus.ready) begin
        seen_result.write_valid = out_bus.write_valid;
        seen_result.rom_address = out_bus.rom_address;
        seen_result.rom_byte    = out_bus.rom_byte;
        seen_result.status      = status_t'(out_bus.status);
        seen_result.bank_count  = out_bus.bank_count;
        seen_result.total_bytes = out_bus.total_bytes;
        sb.check_result(seen_result);
      end
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, stuck_cycles, sb.pending());
        $display("Mismatches found");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // Result side back-pressure
  initial begin
    int stall;
    out_bus.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!(out_bus.valid && out_bus.ready));
    end
  end

  task automatic send_byte(logic [DATA_W-1:0] d, logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= d;
    in_bus.last_byte <= last;
    do @(posedge clk); while (!(in_bus.valid && in_bus.ready));
  endtask

  task automatic wait_all_results();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_length(logic [WORD_W-1:0] v);
    cfg_bus.valid       <= 1'b1;
    cfg_bus.file_length <= v;
    do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
    cfg_bus.valid <= 1'b0;
    sb.file_len = v;
    length_writes++;
  endtask

  // Length register only changes with the block drained
  task automatic send_file(logic [WORD_W-1:0] flen, bit keep);
    if (!keep) begin
      wait_all_results();
      write_length(flen);
    end
    foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
  endtask

  task automatic push_form_header();
    for (int i = 3; i >= 0; i--) file_q.push_back(RIFF_ID[8*i +: 8]);
    repeat (4) file_q.push_back(8'($urandom));
    for (int i = 3; i >= 0; i--) file_q.push_back(FORM_ID[8*i +: 8]);
  endtask

  // One chunk; open_end marks a declared length running past the end of the stream
  task automatic push_chunk(output bit open_end);
    int                kind, n;
    logic [DATA_W-1:0] c0, c1, c2, c3;
    logic [WORD_W-1:0] clen;
    c0 = CH_C;
    c1 = CH_B;
    n = $urandom_range(0, 31);
    c2 = 8'(CH_0 + n / 10);
    c3 = 8'(CH_0 + n % 10);
    kind = $urandom_range(0, 9);
    case (kind)
      5: begin
        // single digit bank, fourth byte anything but a digit
        c2 = 8'(CH_0 + n % 10);
        c3 = 8'($urandom);
        if (c3 >= CH_0 && c3 <= CH_9) c3 = 8'(CH_9 + 1);
      end
      6: begin
        n = $urandom_range(MAX_BANKS, 99);
        c2 = 8'(CH_0 + n / 10);
        c3 = 8'(CH_0 + n % 10);
      end
      7: c2 = $urandom_range(0, 1) ? 8'(CH_0 - 1) : 8'(CH_9 + 1);
      8: begin
        c0 = 8'($urandom);
        c1 = 8'($urandom);
        c2 = 8'($urandom);
        c3 = 8'($urandom);
      end
      9: begin
        if ($urandom_range(0, 1)) c0 = c0 ^ 8'(1 << $urandom_range(0, 7));
        else c1 = c1 ^ 8'(1 << $urandom_range(0, 7));
      end
      default: ;
    endcase
    open_end = 1'b0;
    n = $urandom_range(0, 19);
    if (n < 15) clen = $urandom_range(0, 9);
    else if (n < 18) clen = $urandom_range(10, 40);
    else begin
      clen = $urandom | 32'h0001_0000;
      open_end = 1'b1;
    end
    file_q.push_back(c0);
    file_q.push_back(c1);
    file_q.push_back(c2);
    file_q.push_back(c3);
    for (int i = 0; i < 4; i++) file_q.push_back(clen[8*i +: 8]);
    if (open_end) begin
      repeat ($urandom_range(0, 20)) file_q.push_back(8'($urandom));
    end else begin
      repeat (clen) file_q.push_back(8'($urandom));
      if (clen[0]) file_q.push_back(8'($urandom));
    end
  endtask

  // Mostly well-formed files; some noise, bad signatures and truncations
  task automatic build_file(output logic [WORD_W-1:0] flen, output bit keep);
    int kind, k, sel;
    bit open_end;
    file_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 30)) file_q.push_back(8'($urandom));
    end else begin
      push_form_header();
      if (kind < 18) begin
        k = $urandom_range(0, 7);
        if (k >= 4) k = k + 4;
        file_q[k] = file_q[k] ^ 8'(1 << $urandom_range(0, 7));
      end
      open_end = 1'b0;
      k = $urandom_range(0, 5);
      while (k > 0 && !open_end) begin
        push_chunk(open_end);
        k--;
      end
      // short trailer: too few bytes for another header
      if (!open_end && $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 7)) file_q.push_back(8'($urandom));
      if (kind >= 18 && kind < 28) begin
        k = $urandom_range(1, file_q.size());
        while (file_q.size() > k) void'(file_q.pop_back());
      end
    end
    sel = $urandom_range(0, 99);
    if (sel < 65) flen = file_q.size();
    else if (sel < 75) flen = (file_q.size() > 8) ? file_q.size() - $urandom_range(1, 8) : 0;
    else if (sel < 83) flen = file_q.size() + $urandom_range(1, 20);
    else if (sel < 89) flen = '1;
    else if (sel < 95) flen = $urandom_range(0, FILE_HDR_BYTES - 1);
    else flen = $urandom;
    keep = ($urandom_range(0, 4) == 0);
  endtask

  initial begin
    logic [WORD_W-1:0] flen;
    bit                keep;
    int                rand_files;
    rst_n               <= 1'b0;
    in_bus.valid        <= 1'b0;
    in_bus.data_byte    <= '0;
    in_bus.last_byte    <= 1'b0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.file_length <= '0;
    no_idle = 1'b0;
    stuck_cycles = 0;
    length_writes = 0;
    items_sent = 0;
    rand_files = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: file ends before its header is complete
    file_q = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    send_file(32'd4, 1'b0);
    // Directed: loadable file, top bank, odd length with pad byte
    file_q = '{8'h52, 8'h49, 8'h46, 8'h46, 8'hFF, 8'h00, 8'h5A, 8'h01,
               8'h41, 8'h4D, 8'h53, 8'h21, CH_C, CH_B, 8'h33, 8'h31,
               8'h01, 8'h00, 8'h00, 8'h00, 8'hA5, 8'h00};
    send_file(32'd22, 1'b0);

    // Random files
    while (items_sent < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      build_file(flen, keep);
      if (rand_files == 0) begin
        flen = '0;
        keep = 1'b0;
      end else if (rand_files == 1) begin
        flen = '1;
        keep = 1'b0;
      end
      send_file(flen, keep);
      items_sent += file_q.size();
      rand_files++;
    end

    // Drain, then allow time for anything stray before the final check
    wait_all_results();
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
      sb.errors++;
    end
    $display("Covered %0d files, %0d random bytes, %0d ROM writes, %0d length writes",
             sb.files, items_sent, sb.rom_writes, length_writes);
    $display("Final status: loaded %0d, too small %0d, bad signature %0d, no banks %0d",
             sb.status_seen[ST_LOADED], sb.status_seen[ST_TOO_SMALL],
             sb.status_seen[ST_BAD_SIG], sb.status_seen[ST_NO_BANKS]);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
